// File: design/mwalu_pkg.sv
// mwalu_pkg: operation, width and fault codes plus width helpers for the
// multi-width alu. No dependencies; used by multiwidth_alu_with_flags.
`timescale 1ns / 1ps

package mwalu_pkg;

  // datapath and counter widths
  localparam int DATA_W = 32;
  localparam int CNT_W  = 6;

  // operation codes
  localparam logic [3:0] ACT_ADD = 4'd0;
  localparam logic [3:0] ACT_SUB = 4'd1;
  localparam logic [3:0] ACT_ADC = 4'd2;
  localparam logic [3:0] ACT_SBC = 4'd3;
  localparam logic [3:0] ACT_AND = 4'd4;
  localparam logic [3:0] ACT_OR  = 4'd5;
  localparam logic [3:0] ACT_XOR = 4'd6;
  localparam logic [3:0] ACT_DIV = 4'd7;
  localparam logic [3:0] ACT_MUL = 4'd8;
  localparam logic [3:0] ACT_SHL = 4'd9;
  localparam logic [3:0] ACT_SHR = 4'd10;
  localparam logic [3:0] ACT_ROL = 4'd11;
  localparam logic [3:0] ACT_ROR = 4'd12;
  localparam logic [3:0] ACT_CLC = 4'd13;
  localparam logic [3:0] ACT_SEC = 4'd14;
  localparam logic [3:0] ACT_BAD = 4'd15;

  // operand width codes
  localparam logic [1:0] WC_8   = 2'd0;
  localparam logic [1:0] WC_16  = 2'd1;
  localparam logic [1:0] WC_32  = 2'd2;
  localparam logic [1:0] WC_BAD = 2'd3;

  // fault codes
  localparam logic [1:0] FLT_NONE = 2'd0;
  localparam logic [1:0] FLT_DIV0 = 2'd1;
  localparam logic [1:0] FLT_BAD  = 2'd2;

  typedef logic [DATA_W-1:0] word_t;

  // number of bits for a width code
  function automatic logic [CNT_W-1:0] wc_bits(input logic [1:0] wc);
    logic [CNT_W-1:0] w;
    case (wc)
      WC_8:    w = CNT_W'(8);
      WC_16:   w = CNT_W'(16);
      default: w = CNT_W'(DATA_W);
    endcase
    return w;
  endfunction

  // mask of the live bits for a width code
  function automatic word_t wc_mask(input logic [1:0] wc);
    word_t m;
    case (wc)
      WC_8:    m = word_t'(32'h0000_00ff);
      WC_16:   m = word_t'(32'h0000_ffff);
      default: m = '1;
    endcase
    return m;
  endfunction

  // sign bit of a value at the width
  function automatic logic top_bit(input word_t v, input logic [1:0] wc);
    logic b;
    case (wc)
      WC_8:    b = v[7];
      WC_16:   b = v[15];
      default: b = v[DATA_W-1];
    endcase
    return b;
  endfunction

  // carry out of a sum at the width
  function automatic logic carry_bit(input logic [DATA_W:0] s, input logic [1:0] wc);
    logic b;
    case (wc)
      WC_8:    b = s[8];
      WC_16:   b = s[16];
      default: b = s[DATA_W];
    endcase
    return b;
  endfunction

endpackage

// File: design/multiwidth_alu_with_flags.sv
// multiwidth_alu_with_flags: 8/16/32-bit integer alu with stored nzcv flags,
// iterative multiply and divide on one shared adder. Depends on mwalu_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (in_valid/in_ready): one word carries an action, a width
//   code and two operands. Output channel (out_valid/out_ready): one result
//   word per input word, in order, with the flags as they stand after it.
//   Add, sub, logic, shifts, rotates, clc, sec and any fault finish at the
//   accepting edge, which loads the result into the output register.
//   Multiply and divide run one bit per cycle through a shared 33-bit adder
//   under a small sequencer: w steps in the busy state, then a wrap-up state
//   that loads the result into the output register.
//   in_ready is high only when the sequencer is idle and the output register
//   is empty or being read that cycle, so simple operations stream at one
//   word per cycle while the receiver keeps up.
//   When the receiver stalls, the result word holds in the output register
//   and no new word is taken until it drains.
//   Synchronous active-low reset clears the flags, the sequencer and the
//   output valid; payload registers are not reset.
module multiwidth_alu_with_flags (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [3:0]  in_action,
  input  logic [1:0]  in_width_code,
  input  logic [31:0] in_operand_a,
  input  logic [31:0] in_operand_b,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_result,
  output logic [31:0] out_side_value,
  output logic        out_side_valid,
  output logic        out_flag_negative,
  output logic        out_flag_zero,
  output logic        out_flag_carry,
  output logic        out_flag_overflow,
  output logic [1:0]  out_fault
);

  localparam int DW = mwalu_pkg::DATA_W;
  localparam int CW = mwalu_pkg::CNT_W;

  // sequencer states
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_BUSY = 2'd1;
  localparam logic [1:0] ST_FIN  = 2'd2;

  logic [1:0]          state_r, state_nxt;
  logic [CW-1:0]       cnt_r, cnt_nxt;
  logic                div_r, div_nxt;
  logic [1:0]          wc_r, wc_nxt;
  mwalu_pkg::word_t    acc_r, acc_nxt;
  mwalu_pkg::word_t    sh_r, sh_nxt;
  mwalu_pkg::word_t    b_r, b_nxt;

  logic                n_r, n_nxt, z_r, z_nxt, c_r, c_nxt, v_r, v_nxt;

  logic                out_valid_r, out_valid_nxt;
  mwalu_pkg::word_t    res_r, res_nxt;
  mwalu_pkg::word_t    side_r, side_nxt;
  logic                sidev_r, sidev_nxt;
  logic [1:0]          fault_r, fault_nxt;

  logic                accept;
  mwalu_pkg::word_t    m_in, a_m, b_m;
  logic [CW-1:0]       w_in;
  logic                cin, is_sub;
  logic [4:0]          rot;
  logic [CW-1:0]       rot_back;

  // shared adder operands
  logic [DW:0]         ux, uy, usum;
  logic                uci;

  // combinational result for the simple operations
  mwalu_pkg::word_t    q_res;
  logic [1:0]          q_fault;
  logic                q_iter, q_nz, q_c, q_v;

  // finished multiply or divide
  mwalu_pkg::word_t    f_res, m_fin;

  assign in_ready = (state_r == ST_IDLE) && (!out_valid_r || out_ready);
  assign accept   = in_valid && in_ready;

  // operands at the selected width
  always_comb begin
    m_in     = mwalu_pkg::wc_mask(in_width_code);
    w_in     = mwalu_pkg::wc_bits(in_width_code);
    a_m      = in_operand_a & m_in;
    b_m      = in_operand_b & m_in;
    is_sub   = (in_action == mwalu_pkg::ACT_SUB) || (in_action == mwalu_pkg::ACT_SBC);
    cin      = ((in_action == mwalu_pkg::ACT_ADC) || (in_action == mwalu_pkg::ACT_SBC))
               ? c_r : 1'b0;
    rot      = b_m[4:0] & 5'(w_in - CW'(1));
    rot_back = w_in - CW'(rot);
  end

  // shared adder: add/sub at accept, one multiply or divide step when busy
  always_comb begin
    if (state_r == ST_BUSY) begin
      if (div_r) begin
        ux  = {acc_r, sh_r[DW-1]};
        uy  = ~{1'b0, b_r};
        uci = 1'b1;
      end else begin
        ux  = {1'b0, acc_r};
        uy  = {1'b0, (sh_r[0] ? b_r : '0)};
        uci = 1'b0;
      end
    end else begin
      ux = {1'b0, a_m};
      if (is_sub) begin
        uy  = ~{1'b0, b_m};
        uci = ~cin;
      end else begin
        uy  = {1'b0, b_m};
        uci = cin;
      end
    end
    usum = ux + uy + {{DW{1'b0}}, uci};
  end

  // simple operations and fault checks
  always_comb begin
    q_res   = '0;
    q_fault = mwalu_pkg::FLT_NONE;
    q_iter  = 1'b0;
    q_nz    = 1'b1;
    q_c     = c_r;
    q_v     = v_r;
    if (in_action == mwalu_pkg::ACT_BAD || in_width_code == mwalu_pkg::WC_BAD) begin
      q_fault = mwalu_pkg::FLT_BAD;
      q_nz    = 1'b0;
    end else begin
      case (in_action)
        mwalu_pkg::ACT_ADD, mwalu_pkg::ACT_ADC: begin
          q_res = usum[DW-1:0] & m_in;
          q_c   = mwalu_pkg::carry_bit(usum, in_width_code);
          q_v   = mwalu_pkg::top_bit(~(a_m ^ b_m) & (a_m ^ q_res), in_width_code);
        end
        mwalu_pkg::ACT_SUB, mwalu_pkg::ACT_SBC: begin
          q_res = usum[DW-1:0] & m_in;
          q_c   = usum[DW];
          q_v   = mwalu_pkg::top_bit((a_m ^ b_m) & (a_m ^ q_res), in_width_code);
        end
        mwalu_pkg::ACT_AND: q_res = a_m & b_m;
        mwalu_pkg::ACT_OR:  q_res = a_m | b_m;
        mwalu_pkg::ACT_XOR: q_res = a_m ^ b_m;
        mwalu_pkg::ACT_DIV: begin
          if (b_m == '0) begin
            q_fault = mwalu_pkg::FLT_DIV0;
            q_nz    = 1'b0;
          end else begin
            q_iter = 1'b1;
          end
        end
        mwalu_pkg::ACT_MUL: q_iter = 1'b1;
        mwalu_pkg::ACT_SHL:
          q_res = (b_m >= DW'(w_in)) ? '0 : ((a_m << b_m[4:0]) & m_in);
        mwalu_pkg::ACT_SHR:
          q_res = (b_m >= DW'(w_in)) ? '0 : (a_m >> b_m[4:0]);
        mwalu_pkg::ACT_ROL: q_res = ((a_m << rot) | (a_m >> rot_back)) & m_in;
        mwalu_pkg::ACT_ROR: q_res = ((a_m >> rot) | (a_m << rot_back)) & m_in;
        mwalu_pkg::ACT_CLC: begin
          q_c  = 1'b0;
          q_nz = 1'b0;
        end
        default: begin
          q_c  = 1'b1;
          q_nz = 1'b0;
        end
      endcase
    end
  end

  // wrap-up of multiply or divide
  always_comb begin
    m_fin = mwalu_pkg::wc_mask(wc_r);
    if (div_r) begin
      f_res = sh_r & m_fin;
    end else begin
      f_res = sh_r >> (CW'(DW) - mwalu_pkg::wc_bits(wc_r));
    end
  end

  // sequencer, iteration registers, flags and output register
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    div_nxt       = div_r;
    wc_nxt        = wc_r;
    acc_nxt       = acc_r;
    sh_nxt        = sh_r;
    b_nxt         = b_r;
    n_nxt         = n_r;
    z_nxt         = z_r;
    c_nxt         = c_r;
    v_nxt         = v_r;
    out_valid_nxt = out_valid_r && !out_ready;
    res_nxt       = res_r;
    side_nxt      = side_r;
    sidev_nxt     = sidev_r;
    fault_nxt     = fault_r;

    case (state_r)
      ST_IDLE: begin
        if (accept) begin
          if (q_iter) begin
            state_nxt = ST_BUSY;
            cnt_nxt   = w_in;
            div_nxt   = (in_action == mwalu_pkg::ACT_DIV);
            wc_nxt    = in_width_code;
            acc_nxt   = '0;
            b_nxt     = b_m;
            sh_nxt    = (in_action == mwalu_pkg::ACT_DIV) ? (a_m << (CW'(DW) - w_in)) : a_m;
          end else begin
            out_valid_nxt = 1'b1;
            res_nxt       = q_res;
            side_nxt      = '0;
            sidev_nxt     = 1'b0;
            fault_nxt     = q_fault;
            c_nxt         = q_c;
            v_nxt         = q_v;
            if (q_nz) begin
              n_nxt = mwalu_pkg::top_bit(q_res, in_width_code);
              z_nxt = (q_res == '0);
            end
          end
        end
      end
      ST_BUSY: begin
        if (div_r) begin
          acc_nxt = usum[DW] ? ux[DW-1:0] : usum[DW-1:0];
          sh_nxt  = {sh_r[DW-2:0], ~usum[DW]};
        end else begin
          acc_nxt = usum[DW:1];
          sh_nxt  = {usum[0], sh_r[DW-1:1]};
        end
        cnt_nxt = cnt_r - CW'(1);
        if (cnt_r == CW'(1)) begin
          state_nxt = ST_FIN;
        end
      end
      ST_FIN: begin
        state_nxt     = ST_IDLE;
        out_valid_nxt = 1'b1;
        res_nxt       = f_res;
        side_nxt      = acc_r;
        sidev_nxt     = 1'b1;
        fault_nxt     = mwalu_pkg::FLT_NONE;
        n_nxt         = mwalu_pkg::top_bit(f_res, wc_r);
        z_nxt         = (f_res == '0);
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // control state and flags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      n_r         <= 1'b0;
      z_r         <= 1'b0;
      c_r         <= 1'b0;
      v_r         <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      n_r         <= n_nxt;
      z_r         <= z_nxt;
      c_r         <= c_nxt;
      v_r         <= v_nxt;
    end
  end

  // payload and iteration registers
  always_ff @(posedge clk) begin
    cnt_r   <= cnt_nxt;
    div_r   <= div_nxt;
    wc_r    <= wc_nxt;
    acc_r   <= acc_nxt;
    sh_r    <= sh_nxt;
    b_r     <= b_nxt;
    res_r   <= res_nxt;
    side_r  <= side_nxt;
    sidev_r <= sidev_nxt;
    fault_r <= fault_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_result        = res_r;
  assign out_side_value    = side_r;
  assign out_side_valid    = sidev_r;
  assign out_flag_negative = n_r;
  assign out_flag_zero     = z_r;
  assign out_flag_carry    = c_r;
  assign out_flag_overflow = v_r;
  assign out_fault         = fault_r;

endmodule

// File: dv/multiwidth_alu_with_flags_test.sv
// multiwidth_alu_with_flags_test: self-checking bench for the multi-width alu.
// Drives directed and random words, predicts result words with nzcv tracking.
// Depends on mwalu_pkg and multiwidth_alu_with_flags.
`timescale 1ns / 1ps

module multiwidth_alu_with_flags_test;

  localparam int RANDOM_WORDS = 1325;
  localparam int STALL_LIMIT  = 2000;
  localparam int TAIL_CYCLES  = 50;

  // one input word and one result word
  typedef struct packed {
    logic [3:0]       action;
    logic [1:0]       wc;
    mwalu_pkg::word_t a;
    mwalu_pkg::word_t b;
  } alu_word_t;

  typedef struct packed {
    mwalu_pkg::word_t result;
    mwalu_pkg::word_t side;
    logic             side_ok;
    logic             n;
    logic             z;
    logic             c;
    logic             v;
    logic [1:0]       fault;
  } alu_result_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [3:0]  in_action = '0;
  logic [1:0]  in_width_code = '0;
  logic [31:0] in_operand_a = '0;
  logic [31:0] in_operand_b = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [31:0] out_result;
  logic [31:0] out_side_value;
  logic        out_side_valid;
  logic        out_flag_negative;
  logic        out_flag_zero;
  logic        out_flag_carry;
  logic        out_flag_overflow;
  logic [1:0]  out_fault;

  multiwidth_alu_with_flags dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_action         (in_action),
    .in_width_code     (in_width_code),
    .in_operand_a      (in_operand_a),
    .in_operand_b      (in_operand_b),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_result        (out_result),
    .out_side_value    (out_side_value),
    .out_side_valid    (out_side_valid),
    .out_flag_negative (out_flag_negative),
    .out_flag_zero     (out_flag_zero),
    .out_flag_carry    (out_flag_carry),
    .out_flag_overflow (out_flag_overflow),
    .out_fault         (out_fault)
  );

  // predicted flag state
  logic st_negative = 1'b0;
  logic st_zero     = 1'b0;
  logic st_carry    = 1'b0;
  logic st_overflow = 1'b0;

  alu_result_t awaited_results[$];
  int          mismatch_count = 0;
  int          stall_cycles = 0;
  bit          calm = 1'b0;

  // expectation that goes with the word on the input port
  bit          cur_known = 1'b0;
  alu_result_t cur_want = '0;

  // directed plan
  alu_word_t   plan_op[$];
  bit          plan_known[$];
  alu_result_t plan_want[$];

  initial begin
    forever #10 clk = ~clk;
  end

  function automatic int width_of(input logic [1:0] wc);
    int w;
    case (wc)
      mwalu_pkg::WC_8:  w = 8;
      mwalu_pkg::WC_16: w = 16;
      default:          w = 32;
    endcase
    return w;
  endfunction

  task automatic report_mismatch(input string what);
    mismatch_count++;
    $display("%0t mismatch: %s", $time, what);
  endtask

  task automatic cmp_field(input string name, input logic [31:0] got,
                           input logic [31:0] want);
    if (got !== want) report_mismatch($sformatf("%s got %h want %h", name, got, want));
  endtask

  // result word and flag update for one input word
  task automatic compute_alu_word(input alu_word_t w, output alu_result_t r);
    logic [63:0] m, a, b, sb, cin, s, res, side;
    int          wbits;
    int          rot;
    bit          sets_nz;
    r = '0;
    res = '0;
    side = '0;
    sets_nz = 1'b1;
    if (w.action == mwalu_pkg::ACT_BAD || w.wc == mwalu_pkg::WC_BAD) begin
      r.fault = mwalu_pkg::FLT_BAD;
      sets_nz = 1'b0;
    end else begin
      wbits = width_of(w.wc);
      m = (64'd1 << wbits) - 64'd1;
      a = {32'd0, w.a} & m;
      b = {32'd0, w.b} & m;
      sb = 64'd1 << (wbits - 1);
      cin = (w.action == mwalu_pkg::ACT_ADC || w.action == mwalu_pkg::ACT_SBC)
            ? {63'd0, st_carry} : 64'd0;
      rot = int'(b & 64'(wbits - 1));
      case (w.action)
        mwalu_pkg::ACT_ADD, mwalu_pkg::ACT_ADC: begin
          s = a + b + cin;
          res = s & m;
          st_carry = s[wbits];
          st_overflow = ((~(a ^ b) & (a ^ res) & sb) != 64'd0);
        end
        mwalu_pkg::ACT_SUB, mwalu_pkg::ACT_SBC: begin
          s = a - b - cin;
          res = s & m;
          st_carry = (a < b + cin);
          st_overflow = (((a ^ b) & (a ^ res) & sb) != 64'd0);
        end
        mwalu_pkg::ACT_AND: res = a & b;
        mwalu_pkg::ACT_OR:  res = a | b;
        mwalu_pkg::ACT_XOR: res = a ^ b;
        mwalu_pkg::ACT_DIV: begin
          if (b == 64'd0) begin
            r.fault = mwalu_pkg::FLT_DIV0;
            sets_nz = 1'b0;
          end else begin
            res = a / b;
            side = a % b;
            r.side_ok = 1'b1;
          end
        end
        mwalu_pkg::ACT_MUL: begin
          s = a * b;
          res = s & m;
          side = (s >> wbits) & m;
          r.side_ok = 1'b1;
        end
        mwalu_pkg::ACT_SHL: res = (b >= 64'(wbits)) ? 64'd0 : ((a << b) & m);
        mwalu_pkg::ACT_SHR: res = (b >= 64'(wbits)) ? 64'd0 : (a >> b);
        mwalu_pkg::ACT_ROL: res = ((a << rot) | (a >> (wbits - rot))) & m;
        mwalu_pkg::ACT_ROR: res = ((a >> rot) | (a << (wbits - rot))) & m;
        mwalu_pkg::ACT_CLC: begin
          st_carry = 1'b0;
          sets_nz = 1'b0;
        end
        default: begin
          st_carry = 1'b1;
          sets_nz = 1'b0;
        end
      endcase
      if (sets_nz) begin
        st_negative = res[wbits-1];
        st_zero = (res == 64'd0);
      end
    end
    r.result = res[31:0];
    r.side = side[31:0];
    r.n = st_negative;
    r.z = st_zero;
    r.c = st_carry;
    r.v = st_overflow;
  endtask

  // scoreboard: drain result words first, then log the accepted input word
  always @(posedge clk) begin : scoreboard
    alu_result_t want;
    alu_result_t guess;
    if (!rst_n) begin
      stall_cycles <= 0;
    end else begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          report_mismatch($sformatf("result word %h with nothing expected", out_result));
        end else begin
          want = awaited_results.pop_front();
          cmp_field("result", out_result, want.result);
          cmp_field("side_value", out_side_value, want.side);
          cmp_field("side_valid", 32'(out_side_valid), 32'(want.side_ok));
          cmp_field("flag_negative", 32'(out_flag_negative), 32'(want.n));
          cmp_field("flag_zero", 32'(out_flag_zero), 32'(want.z));
          cmp_field("flag_carry", 32'(out_flag_carry), 32'(want.c));
          cmp_field("flag_overflow", 32'(out_flag_overflow), 32'(want.v));
          cmp_field("fault", 32'(out_fault), 32'(want.fault));
        end
      end
      if (in_valid && in_ready) begin
        compute_alu_word({in_action, in_width_code, in_operand_a, in_operand_b}, guess);
        if (cur_known) guess = cur_want;
        awaited_results = {awaited_results, guess};
      end
    end
  end

  // receiver stalls
  always @(negedge clk) begin
    out_ready = rst_n && (calm || $urandom_range(0, 99) >= 26);
  end

  // watchdog on cycles with no word moving
  initial begin
    @(posedge rst_n);
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("[multiwidth_alu_with_flags] ERROR");
    $finish;
  end

  task automatic plan_row(input logic [3:0] act, input logic [1:0] wc,
                          input mwalu_pkg::word_t a, input mwalu_pkg::word_t b);
    alu_word_t   op;
    alu_result_t want;
    op = {act, wc, a, b};
    want = '0;
    plan_op = {plan_op, op};
    plan_known = {plan_known, 1'b0};
    plan_want = {plan_want, want};
  endtask

  // row with a result read straight off the spec; nzcv packed msb first
  task automatic plan_fixed(input logic [3:0] act, input logic [1:0] wc,
                            input mwalu_pkg::word_t a, input mwalu_pkg::word_t b,
                            input mwalu_pkg::word_t res, input mwalu_pkg::word_t side,
                            input logic side_ok, input logic [3:0] nzcv,
                            input logic [1:0] fault);
    alu_word_t   op;
    alu_result_t want;
    op = {act, wc, a, b};
    want = {res, side, side_ok, nzcv, fault};
    plan_op = {plan_op, op};
    plan_known = {plan_known, 1'b1};
    plan_want = {plan_want, want};
  endtask

  task automatic sender_idle();
    @(negedge clk);
    in_valid = 1'b0;
    in_action = 4'($urandom);
    in_width_code = 2'($urandom);
    in_operand_a = $urandom;
    in_operand_b = $urandom;
  endtask

  task automatic send_word(input alu_word_t w, input bit known, input alu_result_t want);
    while (!calm && $urandom_range(0, 99) < 26) sender_idle();
    @(negedge clk);
    cur_known = known;
    cur_want = want;
    in_action = w.action;
    in_width_code = w.wc;
    in_operand_a = w.a;
    in_operand_b = w.b;
    in_valid = 1'b1;
    do @(posedge clk); while (!in_ready);
  endtask

  // hold off until every result word has come back
  task automatic drain_results();
    sender_idle();
    while (awaited_results.size() != 0) @(negedge clk);
  endtask

  function automatic mwalu_pkg::word_t pick_operand(input int wbits);
    mwalu_pkg::word_t v;
    mwalu_pkg::word_t m;
    m = mwalu_pkg::word_t'((64'd1 << wbits) - 64'd1);
    v = $urandom;
    case ($urandom_range(0, 9))
      5: v = '0;
      6: v = '1;
      7: v = mwalu_pkg::word_t'(64'd1 << (wbits - 1));
      8: v = mwalu_pkg::word_t'((64'd1 << (wbits - 1)) - 64'd1);
      9: v = $urandom_range(0, 3);
      default: ;
    endcase
    // upper bits beyond the width are either clear or junk
    if ($urandom_range(0, 1) == 0) v = v & m;
    else v = (v & m) | ($urandom & ~m);
    return v;
  endfunction

  function automatic alu_word_t random_word();
    alu_word_t        w;
    int               wbits;
    mwalu_pkg::word_t m;
    if ($urandom_range(0, 99) < 3) w.action = mwalu_pkg::ACT_BAD;
    else w.action = 4'($urandom_range(mwalu_pkg::ACT_ADD, mwalu_pkg::ACT_SEC));
    if ($urandom_range(0, 99) < 3) w.wc = mwalu_pkg::WC_BAD;
    else w.wc = 2'($urandom_range(mwalu_pkg::WC_8, mwalu_pkg::WC_32));
    wbits = width_of(w.wc);
    m = mwalu_pkg::word_t'((64'd1 << wbits) - 64'd1);
    w.a = pick_operand(wbits);
    w.b = pick_operand(wbits);
    case (w.action)
      mwalu_pkg::ACT_SHL, mwalu_pkg::ACT_SHR, mwalu_pkg::ACT_ROL, mwalu_pkg::ACT_ROR: begin
        // mostly amounts around the width
        if ($urandom_range(0, 9) < 7) begin
          w.b = $urandom_range(0, wbits + 2);
          if ($urandom_range(0, 1) == 1) w.b = w.b | ($urandom & ~m);
        end
      end
      mwalu_pkg::ACT_DIV: begin
        if ($urandom_range(0, 9) == 0) w.b = $urandom & ~m;
      end
      default: ;
    endcase
    return w;
  endfunction

  // main stimulus
  initial begin
    alu_word_t w;
    // reset state, faults and extremes with spelled-out results
    plan_fixed(mwalu_pkg::ACT_BAD, mwalu_pkg::WC_8, '1, '1, '0, '0, 1'b0, 4'b0000,
               mwalu_pkg::FLT_BAD);
    plan_fixed(mwalu_pkg::ACT_ADD, mwalu_pkg::WC_8, 32'h0000_00ff, 32'h0000_0001, '0, '0,
               1'b0, 4'b0110, mwalu_pkg::FLT_NONE);
    plan_fixed(mwalu_pkg::ACT_DIV, mwalu_pkg::WC_8, 32'h0000_0005, 32'h0000_0100, '0, '0,
               1'b0, 4'b0110, mwalu_pkg::FLT_DIV0);
    plan_fixed(mwalu_pkg::ACT_ADD, mwalu_pkg::WC_BAD, 32'h1, 32'h1, '0, '0, 1'b0, 4'b0110,
               mwalu_pkg::FLT_BAD);
    plan_fixed(mwalu_pkg::ACT_ADD, mwalu_pkg::WC_32, 32'h7fff_ffff, 32'h1, 32'h8000_0000,
               '0, 1'b0, 4'b1001, mwalu_pkg::FLT_NONE);
    plan_fixed(mwalu_pkg::ACT_SUB, mwalu_pkg::WC_16, 32'h0, 32'h1, 32'h0000_ffff, '0, 1'b0,
               4'b1010, mwalu_pkg::FLT_NONE);
    plan_fixed(mwalu_pkg::ACT_MUL, mwalu_pkg::WC_32, '1, '1, 32'h1, 32'hffff_fffe, 1'b1,
               4'b0010, mwalu_pkg::FLT_NONE);
    // carry chains, logic, divide, multiply
    plan_row(mwalu_pkg::ACT_ADC, mwalu_pkg::WC_16, 32'h0000_7fff, 32'h0);
    plan_row(mwalu_pkg::ACT_SEC, mwalu_pkg::WC_8, 32'h0, 32'h0);
    plan_row(mwalu_pkg::ACT_SBC, mwalu_pkg::WC_32, 32'h0, '1);
    plan_row(mwalu_pkg::ACT_CLC, mwalu_pkg::WC_32, '1, '1);
    plan_row(mwalu_pkg::ACT_ADC, mwalu_pkg::WC_8, 32'hdead_beff, 32'h1234_56ff);
    plan_row(mwalu_pkg::ACT_AND, mwalu_pkg::WC_32, 32'hf0f0_a5a5, 32'hff00_0ff0);
    plan_row(mwalu_pkg::ACT_OR, mwalu_pkg::WC_16, 32'h1234_8001, 32'hffff_0100);
    plan_row(mwalu_pkg::ACT_XOR, mwalu_pkg::WC_8, 32'h0000_005a, 32'hffff_ff5a);
    plan_row(mwalu_pkg::ACT_DIV, mwalu_pkg::WC_32, '1, 32'h7);
    plan_row(mwalu_pkg::ACT_DIV, mwalu_pkg::WC_16, 32'h3, 32'h0000_abcd);
    plan_row(mwalu_pkg::ACT_MUL, mwalu_pkg::WC_8, 32'h80, 32'h80);
    plan_row(mwalu_pkg::ACT_MUL, mwalu_pkg::WC_16, 32'h1234, 32'h5678);
    // shift by the width or more and just below it, rotate modulo the width
    plan_row(mwalu_pkg::ACT_SHL, mwalu_pkg::WC_8, 32'hff, 32'h8);
    plan_row(mwalu_pkg::ACT_SHR, mwalu_pkg::WC_16, 32'hffff, 32'h0001_0010);
    plan_row(mwalu_pkg::ACT_SHL, mwalu_pkg::WC_32, 32'h1, 32'd31);
    plan_row(mwalu_pkg::ACT_ROL, mwalu_pkg::WC_8, 32'h81, 32'd11);
    plan_row(mwalu_pkg::ACT_ROR, mwalu_pkg::WC_32, 32'h8000_0001, 32'd33);
    plan_row(mwalu_pkg::ACT_ROR, mwalu_pkg::WC_16, 32'h8001, 32'h0);

    repeat (11) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    foreach (plan_op[i]) send_word(plan_op[i], plan_known[i], plan_want[i]);
    drain_results();

    for (int i = 0; i < RANDOM_WORDS; i++) begin
      if (i == 300) drain_results();
      calm = (i >= 500 && i < 700);
      w = random_word();
      send_word(w, 1'b0, '0);
    end
    calm = 1'b0;
    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    if (mismatch_count == 0) $display("[multiwidth_alu_with_flags] OK");
    else $display("[multiwidth_alu_with_flags] ERROR");
    $finish;
  end

endmodule
